// ----- hdl/aimb_pkg.sv -----
// Package with widths, register codes and pipeline stage types of the inverse map blitter.
package aimb_pkg;

  // Coordinate width and the widths that follow from it.
  localparam int COORD_BITS    = 12;
  localparam int REG_BITS      = COORD_BITS + 1;
  localparam int DIFF_BITS     = COORD_BITS + 2;
  localparam int DPROD_BITS    = 2 * REG_BITS;
  localparam int DET_BITS      = DPROD_BITS + 1;
  localparam int PROD_BITS     = REG_BITS + DIFF_BITS;
  localparam int MIX_BITS      = PROD_BITS + 1;
  localparam int NUM_BITS      = MIX_BITS + COORD_BITS + 1;
  localparam int SCALE_BITS    = DET_BITS + COORD_BITS;
  localparam int CLIP_BITS     = 2 * COORD_BITS;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = CLIP_BITS;

  // Pipeline depth: five front stages, range check, one stage per quotient bit, output.
  localparam int NUM_STAGES = COORD_BITS + 7;

  typedef logic [COORD_BITS-1:0] coord_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_ORIGIN_X   = 3'd0,
    REG_ORIGIN_Y   = 3'd1,
    REG_AXIS_ONE_X = 3'd2,
    REG_AXIS_ONE_Y = 3'd3,
    REG_AXIS_TWO_X = 3'd4,
    REG_AXIS_TWO_Y = 3'd5,
    REG_CLIP_POS   = 3'd6,
    REG_CLIP_SIZE  = 3'd7
  } cfg_reg_t;

  // Stage 1: origin offsets and determinant products.
  typedef struct packed {
    coord_t                        px;
    coord_t                        py;
    logic signed [DIFF_BITS-1:0]   dx;
    logic signed [DIFF_BITS-1:0]   dy;
    logic signed [DPROD_BITS-1:0]  dp1;
    logic signed [DPROD_BITS-1:0]  dp2;
  } s1_t;

  // Stage 2: cross products and determinant.
  typedef struct packed {
    coord_t                        px;
    coord_t                        py;
    logic signed [PROD_BITS-1:0]   a2dy;
    logic signed [PROD_BITS-1:0]   b2dx;
    logic signed [PROD_BITS-1:0]   b1dx;
    logic signed [PROD_BITS-1:0]   a1dy;
    logic signed [DET_BITS-1:0]    det;
  } s2_t;

  // Stage 3: unscaled numerators and determinant magnitude.
  typedef struct packed {
    coord_t                        px;
    coord_t                        py;
    logic signed [MIX_BITS-1:0]    mx;
    logic signed [MIX_BITS-1:0]    my;
    logic [DET_BITS-1:0]           dabs;
    logic                          dneg;
    logic                          degen;
  } s3_t;

  // Stage 4: scaled numerators and scaled divisor bounds.
  typedef struct packed {
    coord_t                        px;
    coord_t                        py;
    logic signed [NUM_BITS-1:0]    nx;
    logic signed [NUM_BITS-1:0]    ny;
    logic [SCALE_BITS-1:0]         wb;
    logic [SCALE_BITS-1:0]         hb;
    logic [DET_BITS-1:0]           dabs;
    logic                          dneg;
    logic                          degen;
  } s4_t;

  // Stage 5: numerator magnitudes and quotient sign agreement.
  typedef struct packed {
    coord_t                        px;
    coord_t                        py;
    logic [NUM_BITS-1:0]           ax;
    logic [NUM_BITS-1:0]           ay;
    logic                          sgnx;
    logic                          sgny;
    logic [SCALE_BITS-1:0]         wb;
    logic [SCALE_BITS-1:0]         hb;
    logic [DET_BITS-1:0]           dabs;
    logic                          degen;
  } s5_t;

  // Divider stages: partial remainders and quotient bits.
  typedef struct packed {
    coord_t                        px;
    coord_t                        py;
    logic [NUM_BITS-1:0]           remx;
    logic [NUM_BITS-1:0]           remy;
    coord_t                        qx;
    coord_t                        qy;
    logic [DET_BITS-1:0]           dabs;
    logic                          rngx;
    logic                          rngy;
    logic                          sgnx;
    logic                          sgny;
    logic                          degen;
  } div_t;

  // Result request.
  typedef struct packed {
    logic                          hit;
    logic                          degen;
    coord_t                        sx;
    coord_t                        sy;
    coord_t                        px;
    coord_t                        py;
  } res_t;

endpackage

// ----- hdl/aimb_in_if.sv -----
// Pixel request channel carrying a target pixel coordinate.
interface aimb_in_if;
  import aimb_pkg::*;

  logic   valid;
  logic   ready;
  coord_t pixel_x;
  coord_t pixel_y;

  modport source (output valid, output pixel_x, output pixel_y, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

// ----- hdl/aimb_out_if.sv -----
// Result channel carrying the mapped source coordinate and flags.
interface aimb_out_if;
  import aimb_pkg::*;

  logic   valid;
  logic   ready;
  logic   inside_res;
  logic   degenerate;
  coord_t source_x;
  coord_t source_y;
  coord_t dest_x;
  coord_t dest_y;

  modport source (output valid, output inside_res, output degenerate, output source_x,
                  output source_y, output dest_x, output dest_y, input ready);
  modport sink   (input valid, input inside_res, input degenerate, input source_x,
                  input source_y, input dest_x, input dest_y, output ready);
endinterface

// ----- hdl/affine_inverse_map_blit.sv -----
// Inverse affine mapping of target pixels into a source clip for a parallelogram blit.
// The feeder sends one target pixel (pixel_x, pixel_y) per request on in_ch; for each
// one the block returns one request on out_ch with inside_res, degenerate, the absolute
// source coordinate (zero unless inside) and the target coordinate echoed for the write.
// Software writes the origin, the two axis vectors and the source clip position and size
// through cfg_we / cfg_idx / cfg_data while no pixel is in flight.
// From acceptance to the result a pixel passes five stages of offsets, products,
// scaling and magnitudes, a range check, then a restoring divider that settles one
// quotient bit per stage.
// One pixel per clock unless the receiver stalls; every stage carries its own valid bit.
// When the receiver stalls, the full stages nearest the output hold and the empty ones
// keep filling, so requests are still taken until the pipeline is full; nothing is lost
// or repeated.
// A synchronous active-low reset empties the pipeline and clears the configuration
// registers to zero.
module affine_inverse_map_blit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [aimb_pkg::CFG_IDX_BITS-1:0]  cfg_idx,
  input  logic [aimb_pkg::CFG_DATA_BITS-1:0] cfg_data,
  aimb_in_if.sink                          in_ch,
  aimb_out_if.source                       out_ch
);
  import aimb_pkg::*;

  // Configuration registers.
  logic signed [REG_BITS-1:0] ox_r, oy_r, ax1_r, ay1_r, ax2_r, ay2_r;
  logic [CLIP_BITS-1:0]       clip_pos_r, clip_size_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ox_r        <= '0;
      oy_r        <= '0;
      ax1_r       <= '0;
      ay1_r       <= '0;
      ax2_r       <= '0;
      ay2_r       <= '0;
      clip_pos_r  <= '0;
      clip_size_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_idx))
        REG_ORIGIN_X:   ox_r        <= cfg_data[REG_BITS-1:0];
        REG_ORIGIN_Y:   oy_r        <= cfg_data[REG_BITS-1:0];
        REG_AXIS_ONE_X: ax1_r       <= cfg_data[REG_BITS-1:0];
        REG_AXIS_ONE_Y: ay1_r       <= cfg_data[REG_BITS-1:0];
        REG_AXIS_TWO_X: ax2_r       <= cfg_data[REG_BITS-1:0];
        REG_AXIS_TWO_Y: ay2_r       <= cfg_data[REG_BITS-1:0];
        REG_CLIP_POS:   clip_pos_r  <= cfg_data[CLIP_BITS-1:0];
        REG_CLIP_SIZE:  clip_size_r <= cfg_data[CLIP_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Fields of the clip registers.
  coord_t clip_left, clip_top, clip_w, clip_h;
  assign clip_left = clip_pos_r[COORD_BITS-1:0];
  assign clip_top  = clip_pos_r[CLIP_BITS-1:COORD_BITS];
  assign clip_w    = clip_size_r[COORD_BITS-1:0];
  assign clip_h    = clip_size_r[CLIP_BITS-1:COORD_BITS];

  // Valid bits and advance chain: a stage loads when it is empty or its successor loads.
  logic [NUM_STAGES-1:0] vld_r;
  logic [NUM_STAGES-1:0] adv;

  always_comb begin
    adv[NUM_STAGES-1] = out_ch.ready || !vld_r[NUM_STAGES-1];
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      adv[k] = adv[k+1] || !vld_r[k];
    end
  end

  assign in_ch.ready = adv[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) begin
        vld_r[0] <= in_ch.valid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (adv[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  // Stage 1: subtract the origin and form the determinant products.
  s1_t s1_nxt, s1_r;

  always_comb begin
    s1_nxt.px  = in_ch.pixel_x;
    s1_nxt.py  = in_ch.pixel_y;
    s1_nxt.dx  = signed'({2'b00, in_ch.pixel_x}) - signed'({ox_r[REG_BITS-1], ox_r});
    s1_nxt.dy  = signed'({2'b00, in_ch.pixel_y}) - signed'({oy_r[REG_BITS-1], oy_r});
    s1_nxt.dp1 = ax2_r * ay1_r;
    s1_nxt.dp2 = ay2_r * ax1_r;
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s1_r <= s1_nxt;
    end
  end

  // Stage 2: cross products with the offsets, and the determinant.
  s2_t s2_nxt, s2_r;
  logic signed [DIFF_BITS-1:0]  s1_dx, s1_dy;
  logic signed [DPROD_BITS-1:0] s1_dp1, s1_dp2;

  always_comb begin
    s1_dx       = signed'(s1_r.dx);
    s1_dy       = signed'(s1_r.dy);
    s1_dp1      = signed'(s1_r.dp1);
    s1_dp2      = signed'(s1_r.dp2);
    s2_nxt.px   = s1_r.px;
    s2_nxt.py   = s1_r.py;
    s2_nxt.a2dy = ax2_r * s1_dy;
    s2_nxt.b2dx = ay2_r * s1_dx;
    s2_nxt.b1dx = ay1_r * s1_dx;
    s2_nxt.a1dy = ax1_r * s1_dy;
    s2_nxt.det  = DET_BITS'(s1_dp1) - DET_BITS'(s1_dp2);
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s2_r <= s2_nxt;
    end
  end

  // Stage 3: numerator differences and determinant magnitude.
  s3_t s3_nxt, s3_r;
  logic signed [DET_BITS-1:0] s2_det;

  always_comb begin
    s2_det       = signed'(s2_r.det);
    s3_nxt.px    = s2_r.px;
    s3_nxt.py    = s2_r.py;
    s3_nxt.mx    = MIX_BITS'(signed'(s2_r.a2dy)) - MIX_BITS'(signed'(s2_r.b2dx));
    s3_nxt.my    = MIX_BITS'(signed'(s2_r.b1dx)) - MIX_BITS'(signed'(s2_r.a1dy));
    s3_nxt.dabs  = s2_det[DET_BITS-1] ? unsigned'(-s2_det) : unsigned'(s2_det);
    s3_nxt.dneg  = s2_det[DET_BITS-1];
    s3_nxt.degen = (s2_det == '0);
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      s3_r <= s3_nxt;
    end
  end

  // Stage 4: scale by the clip size; the clip size times the divisor bounds the quotient.
  s4_t s4_nxt, s4_r;
  logic signed [COORD_BITS:0] w_s, h_s;

  always_comb begin
    w_s          = signed'({1'b0, clip_w});
    h_s          = signed'({1'b0, clip_h});
    s4_nxt.px    = s3_r.px;
    s4_nxt.py    = s3_r.py;
    s4_nxt.nx    = w_s * signed'(s3_r.mx);
    s4_nxt.ny    = h_s * signed'(s3_r.my);
    s4_nxt.wb    = clip_w * s3_r.dabs;
    s4_nxt.hb    = clip_h * s3_r.dabs;
    s4_nxt.dabs  = s3_r.dabs;
    s4_nxt.dneg  = s3_r.dneg;
    s4_nxt.degen = s3_r.degen;
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      s4_r <= s4_nxt;
    end
  end

  // Stage 5: numerator magnitudes; a nonzero quotient is positive when the signs agree.
  s5_t s5_nxt, s5_r;
  logic signed [NUM_BITS-1:0] s4_nx, s4_ny;

  always_comb begin
    s4_nx        = signed'(s4_r.nx);
    s4_ny        = signed'(s4_r.ny);
    s5_nxt.px    = s4_r.px;
    s5_nxt.py    = s4_r.py;
    s5_nxt.ax    = s4_nx[NUM_BITS-1] ? unsigned'(-s4_nx) : unsigned'(s4_nx);
    s5_nxt.ay    = s4_ny[NUM_BITS-1] ? unsigned'(-s4_ny) : unsigned'(s4_ny);
    s5_nxt.sgnx  = (s4_nx[NUM_BITS-1] == s4_r.dneg);
    s5_nxt.sgny  = (s4_ny[NUM_BITS-1] == s4_r.dneg);
    s5_nxt.wb    = s4_r.wb;
    s5_nxt.hb    = s4_r.hb;
    s5_nxt.dabs  = s4_r.dabs;
    s5_nxt.degen = s4_r.degen;
  end

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      s5_r <= s5_nxt;
    end
  end

  // Stage 6: the quotient is below the clip size exactly when the magnitude is below
  // size times divisor; only then does it fit the coordinate width of the divider.
  div_t dv_r [0:COORD_BITS];
  div_t dv0_nxt;

  always_comb begin
    dv0_nxt.px    = s5_r.px;
    dv0_nxt.py    = s5_r.py;
    dv0_nxt.remx  = s5_r.ax;
    dv0_nxt.remy  = s5_r.ay;
    dv0_nxt.qx    = '0;
    dv0_nxt.qy    = '0;
    dv0_nxt.dabs  = s5_r.dabs;
    dv0_nxt.rngx  = (s5_r.ax < NUM_BITS'(s5_r.wb));
    dv0_nxt.rngy  = (s5_r.ay < NUM_BITS'(s5_r.hb));
    dv0_nxt.sgnx  = s5_r.sgnx;
    dv0_nxt.sgny  = s5_r.sgny;
    dv0_nxt.degen = s5_r.degen;
  end

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      dv_r[0] <= dv0_nxt;
    end
  end

  // Restoring divider: each stage settles one quotient bit, most significant first.
  for (genvar j = 0; j < COORD_BITS; j++) begin : g_div
    localparam int SH = COORD_BITS - 1 - j;
    div_t                dv_nxt;
    logic [NUM_BITS-1:0] dsh;

    always_comb begin
      dsh    = NUM_BITS'(dv_r[j].dabs) << SH;
      dv_nxt = dv_r[j];
      if (dv_r[j].remx >= dsh) begin
        dv_nxt.remx   = dv_r[j].remx - dsh;
        dv_nxt.qx[SH] = 1'b1;
      end
      if (dv_r[j].remy >= dsh) begin
        dv_nxt.remy   = dv_r[j].remy - dsh;
        dv_nxt.qy[SH] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (adv[6+j]) begin
        dv_r[j+1] <= dv_nxt;
      end
    end
  end

  // Output stage: a zero quotient is always non-negative; add the clip corner.
  res_t res_nxt, res_r;
  div_t dl;
  logic inx, iny;

  always_comb begin
    dl             = dv_r[COORD_BITS];
    inx            = dl.rngx && ((dl.qx == '0) || dl.sgnx);
    iny            = dl.rngy && ((dl.qy == '0) || dl.sgny);
    res_nxt.hit    = !dl.degen && inx && iny;
    res_nxt.degen  = dl.degen;
    res_nxt.sx     = res_nxt.hit ? coord_t'(clip_left + dl.qx) : '0;
    res_nxt.sy     = res_nxt.hit ? coord_t'(clip_top + dl.qy) : '0;
    res_nxt.px     = dl.px;
    res_nxt.py     = dl.py;
  end

  always_ff @(posedge clk) begin
    if (adv[NUM_STAGES-1]) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid      = vld_r[NUM_STAGES-1];
  assign out_ch.inside_res = res_r.hit;
  assign out_ch.degenerate = res_r.degen;
  assign out_ch.source_x   = res_r.sx;
  assign out_ch.source_y   = res_r.sy;
  assign out_ch.dest_x     = res_r.px;
  assign out_ch.dest_y     = res_r.py;

endmodule
